// File: hdl/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// shared register indexes and pipeline flag type for the incidence current block
// ----------------------------------------------------------------------------
package sic_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z    = 8'd3;

    // control flags that travel with each request down the pipe
    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
    } t_flags;

endpackage

// File: hdl/sic_light_if.sv
// ----------------------------------------------------------------------------
// sic_light_if
// light vector request channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sic_light_if #(
    parameter int COMPONENT_WIDTH = 16
);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] light_x;
    logic signed [COMPONENT_WIDTH-1:0] light_y;
    logic signed [COMPONENT_WIDTH-1:0] light_z;

    modport source (output valid, light_x, light_y, light_z, input ready);
    modport sink   (input valid, light_x, light_y, light_z, output ready);
endinterface

// File: hdl/sic_current_if.sv
// ----------------------------------------------------------------------------
// sic_current_if
// cell current result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sic_current_if #(
    parameter int CURRENT_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [CURRENT_WIDTH:0] cell_current;
    logic                          zero_length;

    modport source (output valid, cell_current, zero_length, input ready);
    modport sink   (input valid, cell_current, zero_length, output ready);
endinterface

// File: hdl/sic_front.sv
// ----------------------------------------------------------------------------
// sic_front
// products, dot product and squared lengths, then length product and scaling
// ----------------------------------------------------------------------------
module sic_front #(
    parameter int CW = 16,
    parameter int IW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [CW-1:0]  i_lx,
    input  logic signed [CW-1:0]  i_ly,
    input  logic signed [CW-1:0]  i_lz,
    input  logic signed [CW-1:0]  i_nx,
    input  logic signed [CW-1:0]  i_ny,
    input  logic signed [CW-1:0]  i_nz,
    input  logic [IW-1:0]         i_max,
    output sic_pkg::t_flags       o_flags,
    output logic [4*CW-1:0]       o_lm,
    output logic [IW+2*CW-1:0]    o_md,
    output logic [2*CW-1:0]       o_dm
);
    localparam int PW = 2 * CW;
    localparam int DW = 2 * CW + 2;

    // stage 1: nine products
    logic                 r1_v;
    logic signed [PW-1:0] r1_dx, r1_dy, r1_dz;
    logic signed [PW-1:0] r1_lx, r1_ly, r1_lz;
    logic signed [PW-1:0] r1_nx, r1_ny, r1_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx <= i_lx * i_nx;
            r1_dy <= i_ly * i_ny;
            r1_dz <= i_lz * i_nz;
            r1_lx <= i_lx * i_lx;
            r1_ly <= i_ly * i_ly;
            r1_lz <= i_lz * i_lz;
            r1_nx <= i_nx * i_nx;
            r1_ny <= i_ny * i_ny;
            r1_nz <= i_nz * i_nz;
        end
    end

    // stage 2: sums
    logic                 r2_v;
    logic signed [DW-1:0] r2_dot;
    logic [PW-1:0]        r2_l2, r2_n2;
    logic signed [DW-1:0] n2_dot;

    assign n2_dot = $signed({{2{r1_dx[PW-1]}}, r1_dx})
                  + $signed({{2{r1_dy[PW-1]}}, r1_dy})
                  + $signed({{2{r1_dz[PW-1]}}, r1_dz});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dot <= n2_dot;
            r2_l2  <= $unsigned(r1_lx) + $unsigned(r1_ly) + $unsigned(r1_lz);
            r2_n2  <= $unsigned(r1_nx) + $unsigned(r1_ny) + $unsigned(r1_nz);
        end
    end

    // stage 3: length product, magnitude scaling, zero check
    logic [DW-1:0]     n3_abs;
    logic [PW-1:0]     n3_dm;
    sic_pkg::t_flags   r3_flags;
    logic [4*CW-1:0]   r3_lm;
    logic [IW+PW-1:0]  r3_md;
    logic [PW-1:0]     r3_dm;

    assign n3_abs = r2_dot[DW-1] ? $unsigned(-r2_dot) : $unsigned(r2_dot);
    assign n3_dm  = n3_abs[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_flags <= '0;
        end else if (i_en) begin
            r3_flags.valid <= r2_v;
            r3_flags.neg   <= r2_dot[DW-1];
            r3_flags.zero  <= (r2_l2 == '0) || (r2_n2 == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_lm <= r2_l2 * r2_n2;
            r3_md <= i_max * n3_dm;
            r3_dm <= n3_dm;
        end
    end

    assign o_flags = r3_flags;
    assign o_lm    = r3_lm;
    assign o_md    = r3_md;
    assign o_dm    = r3_dm;
endmodule

// File: hdl/sic_sqrt.sv
// ----------------------------------------------------------------------------
// sic_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module sic_sqrt #(
    parameter int CW     = 16,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  sic_pkg::t_flags   i_flags,
    input  logic [4*CW-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output sic_pkg::t_flags   o_flags,
    output logic [2*CW-1:0]   o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int N  = 2 * CW;
    localparam int XW = 4 * CW;
    localparam int RW = 2 * CW + 2;

    sic_pkg::t_flags   w_fl   [0:N];
    logic [XW-1:0]     w_rad  [0:N];
    logic [RW-1:0]     w_rem  [0:N];
    logic [N-1:0]      w_root [0:N];
    logic [SIDE_W-1:0] w_side [0:N];

    assign w_fl[0]   = i_flags;
    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < N; k++) begin : g_stage
        sic_pkg::t_flags   r_fl;
        logic [XW-1:0]     r_rad;
        logic [RW-1:0]     r_rem;
        logic [N-1:0]      r_root;
        logic [SIDE_W-1:0] r_side;
        logic [RW-1:0]     n_sh;
        logic [RW-1:0]     n_trial;
        logic              n_fit;

        // bring down two radicand bits and try the next root bit
        assign n_sh    = {w_rem[k][RW-3:0], w_rad[k][XW-1 -: 2]};
        assign n_trial = {w_root[k], 2'b01};
        assign n_fit   = n_sh >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fl <= '0;
            end else if (i_en) begin
                r_fl <= w_fl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad  <= {w_rad[k][XW-3:0], 2'b00};
                r_rem  <= n_fit ? (n_sh - n_trial) : n_sh;
                r_root <= {w_root[k][N-2:0], n_fit};
                r_side <= w_side[k];
            end
        end

        assign w_fl[k+1]   = r_fl;
        assign w_rad[k+1]  = r_rad;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_side[k+1] = r_side;
    end

    assign o_flags = w_fl[N];
    assign o_root  = w_root[N];
    assign o_side  = w_side[N];
endmodule

// File: hdl/sic_div.sv
// ----------------------------------------------------------------------------
// sic_div
// saturation check and pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module sic_div #(
    parameter int CW = 16,
    parameter int IW = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  sic_pkg::t_flags    i_flags,
    input  logic [IW+2*CW-1:0] i_md,
    input  logic [2*CW-1:0]    i_den,
    input  logic [2*CW-1:0]    i_dm,
    output sic_pkg::t_flags    o_flags,
    output logic               o_sat,
    output logic [IW-1:0]      o_q
);
    localparam int DW = 2 * CW;

    sic_pkg::t_flags w_fl  [0:IW];
    logic            w_sat [0:IW];
    logic [DW-1:0]   w_rem [0:IW];
    logic [IW-1:0]   w_low [0:IW];
    logic [DW-1:0]   w_den [0:IW];
    logic [IW-1:0]   w_q   [0:IW];

    // entry stage: saturation test and split of the numerator
    sic_pkg::t_flags r0_fl;
    logic            r0_sat;
    logic [DW-1:0]   r0_rem;
    logic [IW-1:0]   r0_low;
    logic [DW-1:0]   r0_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_fl <= '0;
        end else if (i_en) begin
            r0_fl <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_sat <= i_dm >= i_den;
            r0_rem <= i_md[IW+DW-1:IW];
            r0_low <= i_md[IW-1:0];
            r0_den <= i_den;
        end
    end

    assign w_fl[0]  = r0_fl;
    assign w_sat[0] = r0_sat;
    assign w_rem[0] = r0_rem;
    assign w_low[0] = r0_low;
    assign w_den[0] = r0_den;
    assign w_q[0]   = '0;

    for (genvar k = 0; k < IW; k++) begin : g_stage
        sic_pkg::t_flags r_fl;
        logic            r_sat;
        logic [DW-1:0]   r_rem;
        logic [IW-1:0]   r_low;
        logic [DW-1:0]   r_den;
        logic [IW-1:0]   r_q;
        logic [DW:0]     n_sh;
        logic [DW:0]     n_diff;
        logic            n_fit;

        // shift in the next numerator bit and subtract when it fits
        assign n_sh   = {w_rem[k], w_low[k][IW-1]};
        assign n_fit  = n_sh >= {1'b0, w_den[k]};
        assign n_diff = n_sh - {1'b0, w_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fl <= '0;
            end else if (i_en) begin
                r_fl <= w_fl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat <= w_sat[k];
                r_rem <= n_fit ? n_diff[DW-1:0] : n_sh[DW-1:0];
                r_low <= {w_low[k][IW-2:0], 1'b0};
                r_den <= w_den[k];
                r_q   <= {w_q[k][IW-2:0], n_fit};
            end
        end

        assign w_fl[k+1]  = r_fl;
        assign w_sat[k+1] = r_sat;
        assign w_rem[k+1] = r_rem;
        assign w_low[k+1] = r_low;
        assign w_den[k+1] = r_den;
        assign w_q[k+1]   = r_q;
    end

    assign o_flags = w_fl[IW];
    assign o_sat   = w_sat[IW];
    assign o_q     = w_q[IW];
endmodule

// File: hdl/solar_incidence_current.sv
// ----------------------------------------------------------------------------
// solar_incidence_current
// panel current from the cosine of light against the panel normal
// ----------------------------------------------------------------------------
//  channel    dir  payload                          accepted when
//  i_light    in   light_x, light_y, light_z        valid && ready
//  o_current  out  cell_current, zero_length        valid && ready
//  i_cfg_*    in   index, data (four registers)     i_cfg_we
//
//  one request per cycle while the output is taken; the root and divider
//  resolve one bit per stage. Whole pipe advances together; it stalls only
//  while the output register holds a result that is not taken, and
//  i_light.ready follows that. Synchronous active-low reset clears valid
//  bits, sets normal x to 32767 and clears the rest of the configuration
// ----------------------------------------------------------------------------
module solar_incidence_current #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int CURRENT_WIDTH   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sic_light_if.sink                     i_light,
    sic_current_if.source                 o_current,
    input  logic                          i_cfg_we,
    input  logic [sic_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [((CURRENT_WIDTH > COMPONENT_WIDTH) ?
                   CURRENT_WIDTH : COMPONENT_WIDTH)-1:0] i_cfg_data
);
    localparam int CW     = COMPONENT_WIDTH;
    localparam int IW     = CURRENT_WIDTH;
    localparam int SIDE_W = 2 * CW + IW + 2 * CW;
    localparam logic [CW-1:0] NX_RESET = CW'(32'd32767);

    // configuration registers
    logic [IW-1:0]        r_max;
    logic signed [CW-1:0] r_nx, r_ny, r_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
            r_nx  <= NX_RESET;
            r_ny  <= '0;
            r_nz  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sic_pkg::CFG_MAX_CURRENT: r_max <= i_cfg_data[IW-1:0];
                sic_pkg::CFG_NORMAL_X:    r_nx  <= i_cfg_data[CW-1:0];
                sic_pkg::CFG_NORMAL_Y:    r_ny  <= i_cfg_data[CW-1:0];
                sic_pkg::CFG_NORMAL_Z:    r_nz  <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // pipe advance
    logic r_out_v;
    logic w_en;

    assign w_en          = !r_out_v || o_current.ready;
    assign i_light.ready = w_en;

    // dot product, lengths and scaling
    sic_pkg::t_flags    w_f_fl;
    logic [4*CW-1:0]    w_f_lm;
    logic [IW+2*CW-1:0] w_f_md;
    logic [2*CW-1:0]    w_f_dm;

    sic_front #(.CW(CW), .IW(IW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_light.valid),
        .i_lx    (i_light.light_x),
        .i_ly    (i_light.light_y),
        .i_lz    (i_light.light_z),
        .i_nx    (r_nx),
        .i_ny    (r_ny),
        .i_nz    (r_nz),
        .i_max   (r_max),
        .o_flags (w_f_fl),
        .o_lm    (w_f_lm),
        .o_md    (w_f_md),
        .o_dm    (w_f_dm)
    );

    // root of the length product
    sic_pkg::t_flags   w_s_fl;
    logic [2*CW-1:0]   w_s_root;
    logic [SIDE_W-1:0] w_s_side;

    sic_sqrt #(.CW(CW), .SIDE_W(SIDE_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_flags (w_f_fl),
        .i_rad   (w_f_lm),
        .i_side  ({w_f_dm, w_f_md}),
        .o_flags (w_s_fl),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    // quotient
    sic_pkg::t_flags w_d_fl;
    logic            w_d_sat;
    logic [IW-1:0]   w_d_q;

    sic_div #(.CW(CW), .IW(IW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_flags (w_s_fl),
        .i_md    (w_s_side[IW+2*CW-1:0]),
        .i_den   (w_s_root),
        .i_dm    (w_s_side[SIDE_W-1 -: 2*CW]),
        .o_flags (w_d_fl),
        .o_sat   (w_d_sat),
        .o_q     (w_d_q)
    );

    // clamp, sign and output register
    logic [IW-1:0]     n_q;
    logic [IW:0]       n_cell;
    logic signed [IW:0] r_cell;
    logic              r_zero;

    always_comb begin
        n_q = w_d_sat ? r_max : w_d_q;
        if (n_q > r_max) begin
            n_q = r_max;
        end
        n_cell = w_d_fl.neg ? -{1'b0, n_q} : {1'b0, n_q};
        if (w_d_fl.zero) begin
            n_cell = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_d_fl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cell <= $signed(n_cell);
            r_zero <= w_d_fl.zero;
        end
    end

    assign o_current.valid        = r_out_v;
    assign o_current.cell_current = r_cell;
    assign o_current.zero_length  = r_zero;

    // checks
    a_zero_gives_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_zero |-> r_cell == '0)
        else $error("zero-length result with nonzero current");

    a_within_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_cell <= $signed({1'b0, r_max}))
                 && (r_cell >= -$signed({1'b0, r_max})))
        else $error("current beyond configured maximum");

    a_free_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |-> i_light.ready)
        else $error("pipe stalled with empty output register");
endmodule
